@@ design/rmpa_pkg.sv @@
// ----------------------------------------------------------------------------
// rmpa_pkg
// Shared types and constants for the rate-monotonic priority assignment block.
// ----------------------------------------------------------------------------
package rmpa_pkg;

	localparam int unsigned IdW     = 8;
	localparam int unsigned PeriodW = 16;
	localparam int unsigned PrioW   = 5;

	// one stored task registration
	typedef struct packed {
		logic [PeriodW-1:0] period;
		logic [IdW-1:0]     id;
	} entry_t;

endpackage

@@ design/rmpa_mem.sv @@
// ----------------------------------------------------------------------------
// rmpa_mem
// Task entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rmpa_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic             clk,
	input  logic             wen,
	input  logic [AW-1:0]    waddr,
	input  rmpa_pkg::entry_t wdata,
	input  logic [AW-1:0]    raddr,
	output rmpa_pkg::entry_t rdata
);

	rmpa_pkg::entry_t mem_q [DEPTH];
	rmpa_pkg::entry_t rdata_s1;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		rdata_s1 <= mem_q[raddr];
	end

	assign rdata = rdata_s1;

endmodule

@@ design/rate_monotonic_priority_assign_core.sv @@
// ----------------------------------------------------------------------------
// rate_monotonic_priority_assign_core
// Collects task registrations and hands out rate-monotonic priorities.
// ----------------------------------------------------------------------------
// Use:
//  - Input channel (in_valid/in_ready): one item per task, task_id and
//    period_ticks. Items are taken one per cycle while collecting; up to
//    MAX_TASKS are stored, further ones are dropped without notice.
//  - An item with final_entry set is stored like the rest, then closes the
//    set: in_ready falls while the stored tasks are ranked and emitted.
//  - Ranking: each task is compared against every stored task by a sweep of
//    the entry memory (one read port), giving a stable rank by ascending
//    period.
//  - The tasks are written into a second memory at their rank, then read out
//    in order: each is read, loaded and handed over before the next is read.
//    Results carry out_task_id, priority_res = n - rank + 1, and last_result
//    on the final one.
//  - A stalled receiver simply holds the output register; nothing is lost.
//  - Reset clears the task count and all control; memory contents are left
//    as they are and only written entries are ever used.
// ----------------------------------------------------------------------------
module rate_monotonic_priority_assign_core #(
	parameter int unsigned MAX_TASKS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rmpa_pkg::IdW-1:0]      task_id,
	input  logic [rmpa_pkg::PeriodW-1:0]  period_ticks,
	input  logic                          final_entry,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rmpa_pkg::IdW-1:0]      out_task_id,
	output logic [rmpa_pkg::PrioW-1:0]    priority_res,
	output logic                          last_result
);

	localparam int unsigned IDXW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CNTW = $clog2(MAX_TASKS + 1);
	localparam int unsigned PW   = (CNTW + 1 > rmpa_pkg::PrioW) ? CNTW + 1 : rmpa_pkg::PrioW;

	typedef enum logic [2:0] {
		S_COLLECT,
		S_PIVOT,
		S_LATCH,
		S_SWEEP,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT_WAIT
	} state_t;

	state_t            state_q;
	logic [CNTW-1:0]   cnt_q;      // stored tasks
	logic [IDXW-1:0]   piv_idx_q;  // task being ranked
	logic [IDXW-1:0]   cmp_idx_q;  // index of entry on the read data
	logic [IDXW-1:0]   rank_q;
	logic [IDXW-1:0]   out_idx_q;
	rmpa_pkg::entry_t  piv_q;

	logic                          out_valid_q;
	logic [rmpa_pkg::IdW-1:0]      out_id_q;
	logic [rmpa_pkg::PrioW-1:0]    out_prio_q;
	logic                          out_last_q;

	// memory ports
	logic              ent_wen;
	logic [IDXW-1:0]   ent_waddr;
	logic [IDXW-1:0]   ent_raddr;
	rmpa_pkg::entry_t  ent_wdata;
	rmpa_pkg::entry_t  ent_rdata;
	logic              srt_wen;
	logic [IDXW-1:0]   srt_raddr;
	rmpa_pkg::entry_t  srt_rdata;

	logic              in_acc;
	logic              full;
	logic [CNTW-1:0]   cnt_next;
	logic [IDXW-1:0]   last_idx;
	logic              hit;
	logic [IDXW-1:0]   rank_final;
	logic [PW-1:0]     prio_w;

	assign in_acc   = in_valid && in_ready;
	assign full     = (cnt_q == CNTW'(MAX_TASKS));
	assign cnt_next = full ? cnt_q : cnt_q + CNTW'(1);
	assign last_idx = IDXW'(cnt_q - CNTW'(1));

	// stable order: shorter period first, ties by registration index
	assign hit = (ent_rdata.period < piv_q.period) ||
		((ent_rdata.period == piv_q.period) && (cmp_idx_q < piv_idx_q));
	assign rank_final = rank_q + IDXW'(hit);

	assign prio_w = PW'(cnt_q) - PW'(out_idx_q) + PW'(1);

	// registration writes
	assign ent_wen          = in_acc && !full;
	assign ent_waddr        = cnt_q[IDXW-1:0];
	assign ent_wdata.period = period_ticks;
	assign ent_wdata.id     = task_id;

	always_comb begin
		case (state_q)
			S_PIVOT: ent_raddr = piv_idx_q;
			S_LATCH: ent_raddr = '0;
			default: ent_raddr = cmp_idx_q + IDXW'(1);
		endcase
	end

	// the pivot lands at its rank once its sweep is complete
	assign srt_wen   = (state_q == S_SWEEP) && (cmp_idx_q == last_idx);
	assign srt_raddr = out_idx_q;

	rmpa_mem #(
		.DEPTH(MAX_TASKS),
		.AW   (IDXW)
	) u_entry_mem (
		.clk  (clk),
		.wen  (ent_wen),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	rmpa_mem #(
		.DEPTH(MAX_TASKS),
		.AW   (IDXW)
	) u_sorted_mem (
		.clk  (clk),
		.wen  (srt_wen),
		.waddr(rank_final),
		.wdata(piv_q),
		.raddr(srt_raddr),
		.rdata(srt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			cnt_q       <= '0;
			piv_idx_q   <= '0;
			cmp_idx_q   <= '0;
			rank_q      <= '0;
			out_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_COLLECT: begin
					if (in_acc) begin
						cnt_q <= cnt_next;
						if (final_entry) begin
							piv_idx_q <= '0;
							state_q   <= S_PIVOT;
						end
					end
				end
				S_PIVOT: begin
					state_q <= S_LATCH;
				end
				S_LATCH: begin
					piv_q     <= ent_rdata;
					cmp_idx_q <= '0;
					rank_q    <= '0;
					state_q   <= S_SWEEP;
				end
				S_SWEEP: begin
					if (cmp_idx_q == last_idx) begin
						rank_q <= '0;
						if (piv_idx_q == last_idx) begin
							out_idx_q <= '0;
							state_q   <= S_EMIT_RD;
						end else begin
							piv_idx_q <= piv_idx_q + IDXW'(1);
							state_q   <= S_PIVOT;
						end
					end else begin
						rank_q    <= rank_final;
						cmp_idx_q <= cmp_idx_q + IDXW'(1);
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					out_id_q    <= srt_rdata.id;
					out_prio_q  <= prio_w[rmpa_pkg::PrioW-1:0];
					out_last_q  <= (out_idx_q == last_idx);
					out_valid_q <= 1'b1;
					state_q     <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							cnt_q   <= '0;
							state_q <= S_COLLECT;
						end else begin
							out_idx_q <= out_idx_q + IDXW'(1);
							state_q   <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_COLLECT;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_COLLECT);
	assign out_valid    = out_valid_q;
	assign out_task_id  = out_id_q;
	assign priority_res = out_prio_q;
	assign last_result  = out_last_q;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives task registrations into rate_monotonic_priority_assign_core and
// checks every priority result against a predictor of the stable
// rate-monotonic ranking. The run opens with a short table of hand-picked
// items. After that come random registration sets, some of which overflow
// the task store. Both channels idle at random, and one long output stall
// backs up the input.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IdW         = rmpa_pkg::IdW;
	localparam int unsigned PeriodW     = rmpa_pkg::PeriodW;
	localparam int unsigned PrioW       = rmpa_pkg::PrioW;

	localparam int unsigned MaxTasks    = 16;
	localparam int unsigned TargetItems = 470;
	localparam int unsigned LongStall   = 300;   // cycles the receiver holds off, once
	localparam int unsigned DrainCycles = 60;    // settle time after the last result
	localparam int unsigned CycleLimit  = 200000;

	// one priority result as the block should present it
	typedef struct packed {
		logic [IdW-1:0]   id;
		logic [PrioW-1:0] prio;
		logic             last;
	} prio_result_t;

	// one row of the opening table; the expected result is typed in only for
	// single-task sets, where it is obvious (priority 2, marked last)
	typedef struct packed {
		logic [IdW-1:0]     id;
		logic [PeriodW-1:0] period;
		logic               fin;
		logic               typed;
		prio_result_t       result;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [IdW-1:0]       task_id;
	logic [PeriodW-1:0]   period_ticks;
	logic                 final_entry;
	logic                 out_valid;
	logic                 out_ready;
	logic [IdW-1:0]       out_task_id;
	logic [PrioW-1:0]     priority_res;
	logic                 last_result;

	// predictor state: registrations of the set being collected
	logic [PeriodW-1:0]   held_period [MaxTasks];
	logic [IdW-1:0]       held_id     [MaxTasks];
	int unsigned          held_count;
	bit                   set_overflowed;

	prio_result_t         prio_expect[$];

	int unsigned          fail_count;
	int unsigned          items_sent;
	int unsigned          sets_closed;
	int unsigned          overflow_sets;
	int unsigned          results_checked;
	int unsigned          cycle_count;
	bit                   tx_quiet;
	bit                   rx_quiet;

	// The opening table:
	//  - single-task sets at the extremes of id and period (typed results)
	//  - a mixed set with a period tie, the longest and the shortest period
	//  - a full store of sixteen, with ties, then a final item that arrives
	//    with the store full: it is dropped but still closes the set
	stim_row_t opening_rows [25] = '{
		'{8'hA5, 16'hFFFF, 1'b1, 1'b1, '{8'hA5, 5'd2, 1'b1}},
		'{8'h00, 16'h0000, 1'b1, 1'b1, '{8'h00, 5'd2, 1'b1}},
		'{8'hFF, 16'h0000, 1'b1, 1'b1, '{8'hFF, 5'd2, 1'b1}},
		'{8'h11, 16'h8000, 1'b0, 1'b0, '0},
		'{8'h22, 16'h0005, 1'b0, 1'b0, '0},
		'{8'h33, 16'h0005, 1'b0, 1'b0, '0},
		'{8'h44, 16'hFFFF, 1'b0, 1'b0, '0},
		'{8'h55, 16'h0000, 1'b1, 1'b0, '0},
		'{8'h80, 16'h0100, 1'b0, 1'b0, '0},
		'{8'h81, 16'h0100, 1'b0, 1'b0, '0},
		'{8'h82, 16'h00F0, 1'b0, 1'b0, '0},
		'{8'h83, 16'hFFFF, 1'b0, 1'b0, '0},
		'{8'h84, 16'h00F0, 1'b0, 1'b0, '0},
		'{8'h85, 16'h0002, 1'b0, 1'b0, '0},
		'{8'h86, 16'h7FFF, 1'b0, 1'b0, '0},
		'{8'h87, 16'h0100, 1'b0, 1'b0, '0},
		'{8'h88, 16'h0003, 1'b0, 1'b0, '0},
		'{8'h89, 16'hFFFF, 1'b0, 1'b0, '0},
		'{8'h8A, 16'h0002, 1'b0, 1'b0, '0},
		'{8'h8B, 16'h5555, 1'b0, 1'b0, '0},
		'{8'h8C, 16'hAAAA, 1'b0, 1'b0, '0},
		'{8'h8D, 16'h0003, 1'b0, 1'b0, '0},
		'{8'h8E, 16'h0100, 1'b0, 1'b0, '0},
		'{8'h8F, 16'h0004, 1'b0, 1'b0, '0},
		'{8'h90, 16'h0001, 1'b1, 1'b0, '0}
	};

	rate_monotonic_priority_assign_core #(
		.MAX_TASKS(MaxTasks)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.task_id      (task_id),
		.period_ticks (period_ticks),
		.final_entry  (final_entry),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_task_id  (out_task_id),
		.priority_res (priority_res),
		.last_result  (last_result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: a hung handshake or a missing result ends up here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Stable rank of the held set by ascending period, then one expected
	// result per task: priority counts down from n + 1 to 2, last one marked.
	function automatic void rank_held_set();
		logic [PeriodW-1:0] p;
		logic [IdW-1:0]     id;
		int unsigned        i;
		int unsigned        j;
		prio_result_t       r;
		for (i = 1; i < held_count; i++) begin
			p  = held_period[i];
			id = held_id[i];
			j  = i;
			// strict compare keeps equal periods in arrival order
			while (j > 0 && held_period[j-1] > p) begin
				held_period[j] = held_period[j-1];
				held_id[j]     = held_id[j-1];
				j--;
			end
			held_period[j] = p;
			held_id[j]     = id;
		end
		for (i = 0; i < held_count; i++) begin
			r.id   = held_id[i];
			r.prio = PrioW'(held_count - i + 1);
			r.last = (i + 1 == held_count);
			prio_expect.push_back(r);
		end
	endfunction

	// Predictor step for one accepted registration.
	function automatic void record_registration(logic [IdW-1:0] id,
			logic [PeriodW-1:0] period, logic fin);
		if (held_count < MaxTasks) begin
			held_period[held_count] = period;
			held_id[held_count]     = id;
			held_count++;
		end else begin
			set_overflowed = 1'b1;   // store full: dropped without a trace
		end
		if (fin) begin
			rank_held_set();
			sets_closed++;
			if (set_overflowed)
				overflow_sets++;
			held_count     = 0;
			set_overflowed = 1'b0;
		end
	endfunction

	// Offer one item and return at the edge where it is taken. in_valid only
	// drops when an idle gap is drawn, so back-to-back items keep it high.
	task automatic offer_item(input logic [IdW-1:0] id, input logic [PeriodW-1:0] period,
			input logic fin);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		task_id      <= id;
		period_ticks <= period;
		final_entry  <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		// now and then a stretch with no idling on the input side
		if (items_sent % 40 == 0)
			tx_quiet = ($urandom_range(0, 2) == 0);
	endtask

	// Periods: a fair share from a tiny pool so ties are common, some at the
	// ends of the range, the rest anywhere.
	function automatic logic [PeriodW-1:0] draw_period();
		logic [PeriodW-1:0] p;
		case ($urandom_range(0, 9))
			0, 1, 2: p = PeriodW'($urandom_range(0, 7));
			3:       p = '0;
			4:       p = '1;
			default: p = PeriodW'($urandom_range(0, 16'hFFFF));
		endcase
		return p;
	endfunction

	// Receiver: random hold-off before each result, one long stall on the
	// first large set so the block backs up and in_ready stays low.
	initial begin : receiver
		int unsigned  gap;
		bit           stalled_once;
		prio_result_t want;
		stalled_once = 1'b0;
		out_ready    = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!stalled_once && prio_expect.size() >= 12) begin
				stalled_once = 1'b1;
				out_ready <= 1'b0;
				repeat (LongStall) @(posedge clk);
			end else begin
				gap = rx_quiet ? 0 : $urandom_range(0, 3);
				if (gap != 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (prio_expect.size() == 0) begin
				$error("unexpected result: out_task_id %0d priority_res %0d last_result %0b",
					out_task_id, priority_res, last_result);
				fail_count++;
			end else begin
				want = prio_expect.pop_front();
				if (out_task_id !== want.id) begin
					$error("out_task_id: expected %0d, got %0d", want.id, out_task_id);
					fail_count++;
				end
				if (priority_res !== want.prio) begin
					$error("priority_res: expected %0d, got %0d", want.prio, priority_res);
					fail_count++;
				end
				if (last_result !== want.last) begin
					$error("last_result: expected %0b, got %0b", want.last, last_result);
					fail_count++;
				end
			end
			results_checked++;
			if (results_checked % 40 == 0)
				rx_quiet = ($urandom_range(0, 2) == 0);
		end
	end

	// Main sequence: reset, opening table, random sets, drain.
	initial begin : sender
		int unsigned        row;
		int unsigned        set_len;
		int unsigned        k;
		logic [IdW-1:0]     id;
		logic [PeriodW-1:0] period;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		task_id         = '0;
		period_ticks    = '0;
		final_entry     = 1'b0;
		fail_count      = 0;
		items_sent      = 0;
		sets_closed     = 0;
		overflow_sets   = 0;
		results_checked = 0;
		cycle_count     = 0;
		held_count      = 0;
		set_overflowed  = 1'b0;
		tx_quiet        = 1'b0;
		rx_quiet        = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < $size(opening_rows); row++) begin
			offer_item(opening_rows[row].id, opening_rows[row].period, opening_rows[row].fin);
			if (opening_rows[row].typed) begin
				// typed rows always stand alone in an empty store
				prio_expect.push_back(opening_rows[row].result);
				sets_closed++;
			end else begin
				record_registration(opening_rows[row].id, opening_rows[row].period,
					opening_rows[row].fin);
			end
		end

		// Random sets: mostly up to a full store, about one in six overflows
		// it. The last item of each set carries final_entry.
		while (items_sent < TargetItems) begin
			if ($urandom_range(0, 5) == 0)
				set_len = $urandom_range(MaxTasks + 1, MaxTasks + 4);
			else
				set_len = $urandom_range(1, MaxTasks);
			for (k = 0; k < set_len; k++) begin
				id     = IdW'($urandom_range(0, 255));
				period = draw_period();
				offer_item(id, period, k + 1 == set_len);
				record_registration(id, period, k + 1 == set_len);
			end
		end
		in_valid <= 1'b0;

		while (prio_expect.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d registrations in %0d sets, %0d of them past a full store",
			items_sent, sets_closed, overflow_sets);
		$display("%0d priority results compared field by field, one %0d-cycle output stall",
			results_checked, LongStall);
		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
